@@ rtl/rrd_pkg.sv @@
// rrd_pkg: shared types and constants for the repeated run detector
// holds the input and result payload structs and the per-cell state struct
// no dependencies
package rrd_pkg;

	localparam int CP_W   = 21;
	localparam int CLS_W  = 32;
	localparam int MASK_W = 5;

	// one input character
	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [CLS_W-1:0] char_class;
		logic             last_in_text;
	} in_item_t;

	// one result per start position
	typedef struct packed {
		logic [MASK_W-1:0] repeat_mask;
		logic              last_of_run;
	} out_item_t;

	// contents of one window cell
	typedef struct packed {
		logic             valid;
		logic             term;
		logic [CP_W-1:0]  point;
		logic [CLS_W-1:0] cls;
	} cell_t;

	// per-cell control from the window controller
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

@@ rtl/rrd_cell.sv @@
// rrd_cell: one character slot of the window shift chain
// depends on rrd_pkg (cell_t, cell_ctl_t)
module rrd_cell
	import rrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  cell_t     new_cell,
	input  cell_t     next_cell,
	output cell_t     cell_out
);

	logic  valid_q;
	cell_t data_q;
	cell_t nxt;

	// load wins: a new character lands here even during a shift
	always_comb begin
		priority if (ctl.load) begin
			nxt = new_cell;
		end else if (ctl.shift) begin
			nxt = next_cell;
		end else begin
			nxt = data_q;
			nxt.valid = valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		cell_out = data_q;
		cell_out.valid = valid_q;
	end

endmodule

@@ rtl/rrd_match.sv @@
// rrd_match: comparator array over the head of the window
// depends on rrd_pkg (cell_t, out_item_t, widths)
module rrd_match
	import rrd_pkg::*;
#(
	parameter int NCELL = 8
) (
	input  cell_t            cells [NCELL],
	input  logic [CLS_W-1:0] target_class,
	output out_item_t        result
);

	// longest unit that fits both the window and the mask width
	localparam int LMAX = (NCELL / 2 < MASK_W - 1) ? NCELL / 2 : MASK_W - 1;

	logic [NCELL-1:0]  in_text;
	logic [CLS_W-1:0]  c0;
	logic              run_ok;
	logic              same;
	logic [MASK_W-1:0] mask;

	// a cell belongs to the head's text until the first end-of-text mark
	always_comb begin
		in_text[0] = cells[0].valid;
		for (int i = 1; i < NCELL; i++) begin
			in_text[i] = in_text[i-1] && cells[i].valid && !cells[i-1].term;
		end
	end

	always_comb begin
		c0     = cells[0].cls;
		run_ok = in_text[1] && ((c0 & target_class) != '0) && ((cells[1].cls & c0) != '0);
		mask   = '0;
		for (int l = 2; l <= LMAX; l++) begin
			// search stops at text end or the first class break
			run_ok = run_ok && in_text[2*l-1] && ((cells[l].cls & c0) != '0);
			same = 1'b1;
			for (int p = 0; p < l; p++) begin
				same = same && (cells[p].point == cells[l+p].point);
			end
			mask[l] = run_ok && same;
		end
		result.repeat_mask = mask;
		result.last_of_run = cells[0].term;
	end

endmodule

@@ rtl/repeated_run_detector.sv @@
// repeated_run_detector: top level, window chain, control and result register
// depends on rrd_pkg, rrd_cell, rrd_match
//
// usage
//  - characters enter on the input channel (in_valid/in_ready/in_data), one
//    transfer per cycle, in text order; last_in_text marks the final one
//  - one result per start position leaves on the output channel
//    (out_valid/out_ready/out_data), oldest start first
//  - target_class is written through cfg_we/cfg_wdata while the block is idle
// operation
//  - a chain of MAX_LENGTH cells holds the window, oldest character in cell 0
//  - a fixed comparator array looks at the head cells every cycle; when the
//    window is full, or an end-of-text mark sits in it, the head result is
//    registered and the chain shifts by one
//  - throughput: one character per cycle sustained while out_ready is high; a
//    text end drains its held characters at one result per cycle while the
//    input keeps filling the freed cells, so a new text can follow at once
//  - a result is registered when its start becomes emittable (window full,
//    or end of its text held) and the result register is free to take it
// reset: arst_n empties the window and the result register; target_class
//  clears to zero, which gives empty masks until written
// stall: when out_ready is low while a result is held, the result register holds,
//  the chain stops shifting and in_ready drops once all MAX_LENGTH cells are occupied
module repeated_run_detector
	import rrd_pkg::*;
#(
	parameter int MAX_LENGTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CLS_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_LENGTH + 1);

	// window state
	cell_t            cells [MAX_LENGTH];
	cell_t            new_cell;
	cell_t            empty_cell;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ins_pos;
	logic             any_term;
	logic             emit;
	logic             shift;
	logic             accept;

	// config and result
	logic [CLS_W-1:0] target_class_q;
	logic             out_valid_q;
	out_item_t        out_data_q;
	out_item_t        head_result;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_class_q <= '0;
		end else if (cfg_we) begin
			target_class_q <= cfg_wdata;
		end
	end

	// any held end-of-text mark means the head's text is draining
	always_comb begin
		any_term = 1'b0;
		for (int i = 0; i < MAX_LENGTH; i++) begin
			any_term = any_term || (cells[i].valid && cells[i].term);
		end
	end

	assign emit     = cells[0].valid && (any_term || (cnt_q == CNT_W'(MAX_LENGTH)));
	assign shift    = emit && (!out_valid_q || out_ready);
	assign in_ready = (cnt_q != CNT_W'(MAX_LENGTH)) || shift;
	assign accept   = in_valid && in_ready;

	// new character lands behind the last held one, one lower if shifting
	assign ins_pos = shift ? (cnt_q - CNT_W'(1)) : cnt_q;

	always_comb begin
		new_cell.valid = 1'b1;
		new_cell.term  = in_data.last_in_text;
		new_cell.point = in_data.code_point;
		new_cell.cls   = in_data.char_class;
		empty_cell     = '0;
	end

	// the cell chain
	for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_cell
		cell_ctl_t ctl;
		cell_t     nb;

		assign ctl.shift = shift;
		assign ctl.load  = accept && (ins_pos == CNT_W'(g));

		if (g == MAX_LENGTH - 1) begin : g_tail
			assign nb = empty_cell;
		end else begin : g_mid
			assign nb = cells[g+1];
		end

		rrd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_cell  (new_cell),
			.next_cell (nb),
			.cell_out  (cells[g])
		);
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(accept) - CNT_W'(shift);
		end
	end

	// comparator array over the head of the window
	rrd_match #(
		.NCELL (MAX_LENGTH)
	) u_match (
		.cells        (cells),
		.target_class (target_class_q),
		.result       (head_result)
	);

	// result register, parts the output stall from the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			out_data_q <= head_result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// occupancy never exceeds the chain length
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LENGTH))
		else $error("window occupancy out of range");

	// occupancy count tracks the cell valid bits at both ends of the chain
	a_cnt_cells: assert property (@(posedge clk) disable iff (!arst_n)
		((cnt_q == '0) == !cells[0].valid) &&
		((cnt_q == CNT_W'(MAX_LENGTH)) == cells[MAX_LENGTH-1].valid))
		else $error("occupancy count and cell valid bits disagree");

	// input only stalls with a full window
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> cnt_q == CNT_W'(MAX_LENGTH))
		else $error("input stalled with room in window");

	// a registered result that was not taken is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !shift)
		else $error("result overwritten while stalled");

endmodule
